>>> src/triangle_transform_cull_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the triangle transform and cull block
// Concurrent checks clocked on clk, disabled in reset, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_TRANSFORM_CULL_MACROS_SVH
`define TRIANGLE_TRANSFORM_CULL_MACROS_SVH

`ifndef SYNTHESIS
`define TTC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("ttc assertion failed");
`define TTC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ttc assertion failed");
`else
`define TTC_ASSERT(lbl, prop)
`define TTC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> src/ttc_pkg.sv
// ----------------------------------------------------------------------------
// Triangle transform and cull package
// Field widths and configuration register indices.
// ----------------------------------------------------------------------------
`default_nettype none

package ttc_pkg;

	localparam int COORD_W    = 32;
	localparam int IDS_W      = 48;
	localparam int WORD16_W   = 16;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 48;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_X_WEIGHTS    = 4'd0;
	localparam cfg_idx_t REG_Y_WEIGHTS    = 4'd1;
	localparam cfg_idx_t REG_X_OFFSET     = 4'd2;
	localparam cfg_idx_t REG_Y_OFFSET     = 4'd3;
	localparam cfg_idx_t REG_OFFSET_SCALE = 4'd4;
	localparam cfg_idx_t REG_VIEW_MIN     = 4'd5;
	localparam cfg_idx_t REG_VIEW_MAX     = 4'd6;
	localparam cfg_idx_t REG_BATCH_TAG    = 4'd7;

endpackage

`default_nettype wire

>>> src/ttc_in_if.sv
// ----------------------------------------------------------------------------
// Triangle input channel
// One triangle per beat: nine vertex coordinates, packed indices, batch end.
// ----------------------------------------------------------------------------
`default_nettype none

interface ttc_in_if import ttc_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] ax_in;
	logic signed [COORD_W-1:0] ay_in;
	logic signed [COORD_W-1:0] az_in;
	logic signed [COORD_W-1:0] bx_in;
	logic signed [COORD_W-1:0] by_in;
	logic signed [COORD_W-1:0] bz_in;
	logic signed [COORD_W-1:0] cx_in;
	logic signed [COORD_W-1:0] cy_in;
	logic signed [COORD_W-1:0] cz_in;
	logic [IDS_W-1:0]          vertex_ids;
	logic                      last_in_batch;

	modport source (
		output valid, ax_in, ay_in, az_in, bx_in, by_in, bz_in, cx_in, cy_in, cz_in,
		output vertex_ids, last_in_batch,
		input  ready
	);
	modport sink (
		input  valid, ax_in, ay_in, az_in, bx_in, by_in, bz_in, cx_in, cy_in, cz_in,
		input  vertex_ids, last_in_batch,
		output ready
	);
endinterface

`default_nettype wire

>>> src/ttc_out_if.sv
// ----------------------------------------------------------------------------
// Visible triangle output channel
// One beat per triangle that survives the viewport test.
// ----------------------------------------------------------------------------
`default_nettype none

interface ttc_out_if import ttc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [WORD16_W-1:0] tag_out;
	logic [WORD16_W-1:0] tri_number;
	logic [IDS_W-1:0]    ids_out;
	logic [WORD16_W-1:0] kept_count;

	modport source (
		output valid, tag_out, tri_number, ids_out, kept_count,
		input  ready
	);
	modport sink (
		input  valid, tag_out, tri_number, ids_out, kept_count,
		output ready
	);
endinterface

`default_nettype wire

>>> src/ttc_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Register index and write data, one register per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ttc_cfg_if import ttc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  reg_idx;
	logic [CFG_DATA_W-1:0] wdata;

	modport source (
		output valid, reg_idx, wdata,
		input  ready
	);
	modport sink (
		input  valid, reg_idx, wdata,
		output ready
	);
endinterface

`default_nettype wire

>>> src/triangle_transform_cull.sv
// ----------------------------------------------------------------------------
// Triangle transform and viewport cull
// Projects three vertices to screen x/y, boxes them and drops triangles whose
// box misses the viewport window.
// ----------------------------------------------------------------------------
// Accepts one triangle per clock while ready is high and gives its result, if
// the triangle is kept, through a four-register pipeline: input register,
// eighteen parallel 32x16 products, per-vertex screen coordinates (sum, floor
// to Q16.16, saturation), then bounding box, window test and counters into
// the output register. A stalled output fills the bubbles in front of it
// before ready falls. Configuration is taken on every cycle and must only be
// written while the pipeline is empty.
// ----------------------------------------------------------------------------
`default_nettype none
`include "triangle_transform_cull_macros.svh"

module triangle_transform_cull import ttc_pkg::*; #(
	parameter int COUNT_BITS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	ttc_in_if.sink      tri_in,
	ttc_out_if.source   tri_out,
	ttc_cfg_if.sink     cfg
);

	localparam int PROD_W = COORD_W + WORD16_W;
	localparam int ACC_W  = PROD_W + 6;
	localparam int FLR_W  = ACC_W - 12;

	// configuration
	logic [47:0]               x_weights_q;
	logic [47:0]               y_weights_q;
	logic signed [31:0]        x_offset_q;
	logic signed [31:0]        y_offset_q;
	logic signed [15:0]        offset_scale_q;
	logic signed [31:0]        view_min_q;
	logic signed [31:0]        view_max_q;
	logic [15:0]               batch_tag_q;
	logic signed [PROD_W-1:0]  off_q [2];

	// pipeline
	logic                      v_s1, v_s2, v_s3;
	logic                      en1, en2, en3, en_o;
	logic signed [31:0]        vin_s1 [9];
	logic [IDS_W-1:0]          ids_s1, ids_s2, ids_s3;
	logic                      last_s1, last_s2, last_s3;
	logic signed [15:0]        wt [2][3];
	logic signed [PROD_W-1:0]  prod_s2 [3][2][3];
	logic signed [ACC_W-1:0]   acc [3][2];
	logic signed [FLR_W-1:0]   flr [3][2];
	logic signed [31:0]        scr [3][2];
	logic signed [31:0]        scr_s3 [3][2];
	logic signed [31:0]        bmin [2];
	logic signed [31:0]        bmax [2];
	logic                      keep;

	// counters and result
	logic [COUNT_BITS-1:0]     tri_q;
	logic [COUNT_BITS-1:0]     kept_q;
	logic [COUNT_BITS-1:0]     kept_next;
	logic                      out_valid_q;
	logic [15:0]               tag_q;
	logic [15:0]               tri_num_q;
	logic [IDS_W-1:0]          ids_q;
	logic [15:0]               kept_cnt_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_weights_q    <= 48'd4096;
			y_weights_q    <= 48'd268435456;
			x_offset_q     <= '0;
			y_offset_q     <= '0;
			offset_scale_q <= 16'sd256;
			view_min_q     <= -32'sd65536;
			view_max_q     <= 32'sd65536;
			batch_tag_q    <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.reg_idx)
				REG_X_WEIGHTS:    x_weights_q    <= cfg.wdata[47:0];
				REG_Y_WEIGHTS:    y_weights_q    <= cfg.wdata[47:0];
				REG_X_OFFSET:     x_offset_q     <= cfg.wdata[31:0];
				REG_Y_OFFSET:     y_offset_q     <= cfg.wdata[31:0];
				REG_OFFSET_SCALE: offset_scale_q <= cfg.wdata[15:0];
				REG_VIEW_MIN:     view_min_q     <= cfg.wdata[31:0];
				REG_VIEW_MAX:     view_max_q     <= cfg.wdata[31:0];
				REG_BATCH_TAG:    batch_tag_q    <= cfg.wdata[15:0];
				default: ;
			endcase
		end
	end

	// scaled translations, refreshed every cycle
	always_ff @(posedge clk) begin
		off_q[0] <= x_offset_q * offset_scale_q;
		off_q[1] <= y_offset_q * offset_scale_q;
	end

	// stall chain
	assign en_o = !out_valid_q || tri_out.ready;
	assign en3  = !v_s3 || en_o;
	assign en2  = !v_s2 || en3;
	assign en1  = !v_s1 || en2;
	assign tri_in.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= tri_in.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			vin_s1[0] <= tri_in.ax_in;
			vin_s1[1] <= tri_in.ay_in;
			vin_s1[2] <= tri_in.az_in;
			vin_s1[3] <= tri_in.bx_in;
			vin_s1[4] <= tri_in.by_in;
			vin_s1[5] <= tri_in.bz_in;
			vin_s1[6] <= tri_in.cx_in;
			vin_s1[7] <= tri_in.cy_in;
			vin_s1[8] <= tri_in.cz_in;
			ids_s1    <= tri_in.vertex_ids;
			last_s1   <= tri_in.last_in_batch;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			wt[0][k] = x_weights_q[16*k +: 16];
			wt[1][k] = y_weights_q[16*k +: 16];
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			for (int v = 0; v < 3; v++)
				for (int a = 0; a < 2; a++)
					for (int k = 0; k < 3; k++)
						prod_s2[v][a][k] <= vin_s1[v*3+k] * wt[a][k];
			ids_s2  <= ids_s1;
			last_s2 <= last_s1;
		end
	end

	// sum, floor to Q16.16, saturate
	always_comb begin
		for (int v = 0; v < 3; v++) begin
			for (int a = 0; a < 2; a++) begin
				acc[v][a] = ACC_W'(prod_s2[v][a][0]) + ACC_W'(prod_s2[v][a][1])
					+ ACC_W'(prod_s2[v][a][2]) + (ACC_W'(off_q[a]) <<< 4);
				flr[v][a] = acc[v][a][ACC_W-1:12];
				if (flr[v][a] > FLR_W'(32'sh7FFF_FFFF))
					scr[v][a] = 32'sh7FFF_FFFF;
				else if (flr[v][a] < -FLR_W'(33'sh0_8000_0000))
					scr[v][a] = 32'sh8000_0000;
				else
					scr[v][a] = flr[v][a][31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			scr_s3  <= scr;
			ids_s3  <= ids_s2;
			last_s3 <= last_s2;
		end
	end

	// bounding box and window test
	always_comb begin
		for (int a = 0; a < 2; a++) begin
			bmin[a] = scr_s3[0][a];
			bmax[a] = scr_s3[0][a];
			for (int v = 1; v < 3; v++) begin
				if (scr_s3[v][a] < bmin[a]) bmin[a] = scr_s3[v][a];
				if (scr_s3[v][a] > bmax[a]) bmax[a] = scr_s3[v][a];
			end
		end
		keep = (bmin[0] <= view_max_q) && (bmax[0] >= view_min_q)
			&& (bmin[1] <= view_max_q) && (bmax[1] >= view_min_q);
		kept_next = kept_q + COUNT_BITS'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			tri_q       <= '0;
			kept_q      <= '0;
		end else if (en_o) begin
			out_valid_q <= v_s3 && keep;
			if (v_s3) begin
				if (last_s3) begin
					tri_q  <= '0;
					kept_q <= '0;
				end else begin
					tri_q <= tri_q + COUNT_BITS'(1);
					if (keep) kept_q <= kept_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_o && v_s3 && keep) begin
			tag_q      <= batch_tag_q;
			tri_num_q  <= 16'(tri_q);
			ids_q      <= ids_s3;
			kept_cnt_q <= 16'(kept_next);
		end
	end

	assign tri_out.valid      = out_valid_q;
	assign tri_out.tag_out    = tag_q;
	assign tri_out.tri_number = tri_num_q;
	assign tri_out.ids_out    = ids_q;
	assign tri_out.kept_count = kept_cnt_q;

	`TTC_ASSERT_NEXT(a_batch_clear, v_s3 && en_o && last_s3, tri_q == '0 && kept_q == '0)
	`TTC_ASSERT(a_result_source, $rose(out_valid_q) |-> $past(v_s3))
	`TTC_ASSERT_NEXT(a_s1_hold, v_s1 && !en2, v_s1)
	`TTC_ASSERT(a_kept_step, (kept_q != $past(kept_q) && kept_q != '0) |-> out_valid_q)

endmodule

`default_nettype wire
